/* rtl/bscc_pkg.sv */
// Shared types and constants for the button-set clock counter.
package bscc_pkg;

   localparam int unsigned DEBOUNCE_WIDTH = 8;
   localparam int unsigned DELAY_WIDTH    = 16;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_DELAY_TICKS  = 1'd1;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_THRESHOLD_RESET = 8'd16;
   localparam logic [DELAY_WIDTH-1:0]    WRITE_DELAY_TICKS_RESET  = 16'd256;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_STEP = 8'd1;
   localparam logic [DELAY_WIDTH-1:0]    DELAY_STEP    = 16'd1;

   localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
   localparam logic [3:0] DIGIT_RADIX        = 4'd10;
   localparam logic [2:0] MINUTE_TENS_RADIX  = 3'd6;
   localparam logic [1:0] HOUR_TENS_WRAP     = 2'd2;
   localparam logic [3:0] HOUR_UNITS_WRAP    = 4'd4;

   typedef struct packed {
      logic pulse_line_active;
      logic minute_button_down;
      logic hour_button_down;
   } req_type;

   typedef struct packed {
      logic [5:0] seconds_now;
      logic [3:0] minute_ones;
      logic [2:0] minute_tens_digit;
      logic [3:0] hour_ones;
      logic [1:0] hour_tens_digit;
      logic       rtc_write_pulse;
   } rsp_type;

   // Per-request actions handed from the input side to the time counter.
   typedef struct packed {
      logic clear;
      logic minute_press;
      logic hour_press;
      logic second_edge;
   } ctl_type;

endpackage

/* rtl/bscc_debounce.sv */
// Saturating up/down debounce counter with a press flag.
module bscc_debounce (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 enable,
   input  logic                                 down,
   input  logic [bscc_pkg::DEBOUNCE_WIDTH-1:0]  threshold,
   output logic                                 fresh,
   output logic                                 held_in
);

   logic [bscc_pkg::DEBOUNCE_WIDTH-1:0] count_ff;
   logic [bscc_pkg::DEBOUNCE_WIDTH-1:0] count_in;
   logic                                held_ff;

   always_comb begin
      count_in = count_ff;
      held_in  = held_ff;
      fresh    = 1'b0;
      if (down) begin
         if (count_ff < threshold) begin
            count_in = count_ff + bscc_pkg::DEBOUNCE_STEP;
         end
         if ((count_in == threshold) && !held_ff) begin
            fresh   = 1'b1;
            held_in = 1'b1;
         end
      end else begin
         if (count_ff != '0) begin
            count_in = count_ff - bscc_pkg::DEBOUNCE_STEP;
         end
         if (count_in == '0) begin
            held_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= 1'b0;
      end else if (enable) begin
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* rtl/bscc_time.sv */
// BCD time counter with set actions, carries and the RTC write delay.
module bscc_time (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  bscc_pkg::ctl_type                  ctl,
   input  logic [bscc_pkg::DELAY_WIDTH-1:0]   write_delay_ticks,
   output bscc_pkg::rsp_type                  result
);

   logic [5:0] second_ff, second_in;
   logic [3:0] minute_units_ff, minute_units_in;
   logic [2:0] minute_tens_ff, minute_tens_in;
   logic [3:0] hour_units_ff, hour_units_in;
   logic [1:0] hour_tens_ff, hour_tens_in;
   logic [bscc_pkg::DELAY_WIDTH-1:0] delay_ff, delay_in, delay_load;
   logic write_pulse;

   always_comb begin
      second_in       = second_ff;
      minute_units_in = minute_units_ff;
      minute_tens_in  = minute_tens_ff;
      hour_units_in   = hour_units_ff;
      hour_tens_in    = hour_tens_ff;
      delay_load      = delay_ff;

      if (ctl.clear) begin
         second_in       = '0;
         minute_units_in = '0;
         minute_tens_in  = '0;
         hour_units_in   = '0;
         hour_tens_in    = '0;
         delay_load      = write_delay_ticks;
      end else if (ctl.minute_press) begin
         minute_units_in = minute_units_ff + 4'd1;
         second_in       = '0;
         delay_load      = write_delay_ticks;
      end else if (ctl.hour_press) begin
         hour_units_in = hour_units_ff + 4'd1;
         delay_load    = write_delay_ticks;
      end else if (ctl.second_edge) begin
         second_in = second_ff + 6'd1;
      end

      if (second_in >= bscc_pkg::SECONDS_PER_MINUTE) begin
         second_in       = '0;
         minute_units_in = minute_units_in + 4'd1;
      end
      if (minute_units_in >= bscc_pkg::DIGIT_RADIX) begin
         minute_units_in = '0;
         minute_tens_in  = minute_tens_in + 3'd1;
      end
      if (minute_tens_in >= bscc_pkg::MINUTE_TENS_RADIX) begin
         minute_tens_in = '0;
         hour_units_in  = hour_units_in + 4'd1;
      end
      if (hour_units_in >= bscc_pkg::DIGIT_RADIX) begin
         hour_units_in = '0;
         hour_tens_in  = hour_tens_in + 2'd1;
      end
      if ((hour_tens_in >= bscc_pkg::HOUR_TENS_WRAP) &&
          (hour_units_in >= bscc_pkg::HOUR_UNITS_WRAP)) begin
         hour_units_in = '0;
         hour_tens_in  = '0;
      end

      delay_in    = delay_load;
      write_pulse = 1'b0;
      if (delay_load != '0) begin
         delay_in    = delay_load - bscc_pkg::DELAY_STEP;
         write_pulse = (delay_in == '0);
      end
   end

   always_comb begin
      result.seconds_now       = second_in;
      result.minute_ones       = minute_units_in;
      result.minute_tens_digit = minute_tens_in;
      result.hour_ones         = hour_units_in;
      result.hour_tens_digit   = hour_tens_in;
      result.rtc_write_pulse   = write_pulse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff       <= '0;
         minute_units_ff <= '0;
         minute_tens_ff  <= '0;
         hour_units_ff   <= '0;
         hour_tens_ff    <= '0;
         delay_ff        <= '0;
      end else if (enable) begin
         second_ff       <= second_in;
         minute_units_ff <= minute_units_in;
         minute_tens_ff  <= minute_tens_in;
         hour_units_ff   <= hour_units_in;
         hour_tens_ff    <= hour_tens_in;
         delay_ff        <= delay_in;
      end
   end

endmodule

/* rtl/bscc_out_buffer.sv */
// Result register with a skid stage so requests keep flowing under a stall.
module bscc_out_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  bscc_pkg::rsp_type in_data,
   output logic              in_stall,
   output logic              out_valid,
   output bscc_pkg::rsp_type out_data,
   input  logic              out_stall
);

   logic              main_valid_ff;
   bscc_pkg::rsp_type main_ff;
   logic              skid_valid_ff;
   bscc_pkg::rsp_type skid_ff;
   logic              take;
   logic              accept;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign take      = main_valid_ff && !out_stall;
   assign accept    = in_valid && !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (take || !main_valid_ff) begin
         main_valid_ff <= accept;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            main_ff <= skid_ff;
         end
      end else if (take || !main_valid_ff) begin
         main_ff <= in_data;
      end else if (accept) begin
         skid_ff <= in_data;
      end
   end

endmodule

/* rtl/button_set_clock_counter_top.sv */
// Top level: 24-hour BCD clock counter with debounced minute/hour set buttons.
// The result of an accepted request is registered in the result buffer before rsp_data presents it.
// Throughput: one request per cycle while req_stall is low; the debounce, set and carry logic are combinational.
// A two-entry result buffer (register plus skid) keeps req_stall registered;
// req_stall rises only once both entries hold unaccepted results.
// Reset (synchronous, active high) zeroes the time, debounce and delay state,
// sets the previous pulse level to one and loads threshold 16, write delay 256.
module button_set_clock_counter_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bscc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bscc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write_enable,
   input  logic [bscc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bscc_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   logic [bscc_pkg::DEBOUNCE_WIDTH-1:0] threshold_ff;
   logic [bscc_pkg::DELAY_WIDTH-1:0]    write_delay_ff;
   logic                                pulse_level_ff;
   logic                                accept;
   logic                                minute_fresh, minute_held_in;
   logic                                hour_fresh, hour_held_in;
   bscc_pkg::ctl_type                   ctl;
   bscc_pkg::rsp_type                   result;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= bscc_pkg::DEBOUNCE_THRESHOLD_RESET;
         write_delay_ff <= bscc_pkg::WRITE_DELAY_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            bscc_pkg::CSR_DEBOUNCE_THRESHOLD: begin
               threshold_ff <= csr_write_data[bscc_pkg::DEBOUNCE_WIDTH-1:0];
            end
            bscc_pkg::CSR_WRITE_DELAY_TICKS: begin
               write_delay_ff <= csr_write_data[bscc_pkg::DELAY_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_level_ff <= 1'b1;
      end else if (accept) begin
         pulse_level_ff <= req_data.pulse_line_active;
      end
   end

   bscc_debounce u_minute_debounce (
      .clock     (clock),
      .reset     (reset),
      .enable    (accept),
      .down      (req_data.minute_button_down),
      .threshold (threshold_ff),
      .fresh     (minute_fresh),
      .held_in   (minute_held_in)
   );

   bscc_debounce u_hour_debounce (
      .clock     (clock),
      .reset     (reset),
      .enable    (accept),
      .down      (req_data.hour_button_down),
      .threshold (threshold_ff),
      .fresh     (hour_fresh),
      .held_in   (hour_held_in)
   );

   always_comb begin
      ctl.clear        = minute_held_in && hour_held_in;
      ctl.minute_press = minute_fresh;
      ctl.hour_press   = hour_fresh;
      ctl.second_edge  = req_data.pulse_line_active && !pulse_level_ff;
   end

   bscc_time u_time (
      .clock             (clock),
      .reset             (reset),
      .enable            (accept),
      .ctl               (ctl),
      .write_delay_ticks (write_delay_ff),
      .result            (result)
   );

   bscc_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule
